@@ hdl/htw_pkg.sv @@
// Shared types and constants for the hashed timing wheel.
`default_nettype none
package htw_pkg;
    localparam int SLOTS_DEF      = 16;
    localparam int MAX_TIMERS_DEF = 16;
    localparam int TW             = 20;   // timeout and tick width
    localparam int ID_W           = 16;   // task id width
    localparam int RND_W          = 16;   // rounds width
    localparam int STEP_W         = 16;   // step register width
    localparam logic [STEP_W-1:0] STEP_RST = 16'd10;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_ADD_OK   = 2'd0;
    localparam t_kind KIND_ADD_FULL = 2'd1;
    localparam t_kind KIND_FIRED    = 2'd2;
    localparam t_kind KIND_IDLE     = 2'd3;
endpackage
`default_nettype wire

@@ hdl/htw_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module htw_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [htw_pkg::TW-1:0] i_dividend,
    input  wire logic [htw_pkg::TW-1:0] i_divisor,
    output logic                       o_done,
    output logic [htw_pkg::TW-1:0]     o_quot
);
    import htw_pkg::*;
    localparam int CW = $clog2(TW + 1);

    logic [TW:0]   r_acc, n_acc;
    logic [TW-1:0] r_q, n_q;
    logic [TW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_run, r_done;
    logic [TW:0]   t_sh;

    // Shift in one dividend bit and try the subtract
    always_comb begin
        t_sh  = {r_acc[TW-1:0], r_q[TW-1]};
        if (t_sh >= {1'b0, r_div}) begin
            n_acc = t_sh - {1'b0, r_div};
            n_q   = {r_q[TW-2:0], 1'b1};
        end else begin
            n_acc = t_sh;
            n_q   = {r_q[TW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(TW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_q   <= i_dividend;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_acc <= n_acc;
            r_q   <= n_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

@@ hdl/hashed_timing_wheel.sv @@
// Top level of the hashed timing wheel: sequencer, entry and slot stores.
// An add runs the bit-serial divider (period by step), then splits the ticks
// into rounds, works out the slot and writes the entry, reads the slot and
// links the entry; a full pool answers in the cycle after acceptance. A tick
// reads the slot head, then reads and checks each visited entry, unlinks each
// fired entry it takes out, and links a periodic one that moves to another
// slot into that slot; its last result comes from the end state. Each entry
// read goes through a registered memory port. busy is high while a transaction
// is in work. Results come one per cycle at most on o_valid and must be taken
// when shown; the last one of a transaction carries o_last_result.
`default_nettype none
module hashed_timing_wheel #(
    parameter int SLOTS      = htw_pkg::SLOTS_DEF,
    parameter int MAX_TIMERS = htw_pkg::MAX_TIMERS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_req_type,
    input  wire logic                      i_timer_loop,
    input  wire logic [htw_pkg::TW-1:0]    i_timeout_ms,
    input  wire logic [htw_pkg::ID_W-1:0]  i_task_id,
    input  wire logic                      i_step_ms_we,
    input  wire logic [htw_pkg::STEP_W-1:0] i_step_ms,
    output logic                           o_valid,
    output htw_pkg::t_kind                 o_out_kind,
    output logic [htw_pkg::ID_W-1:0]       o_fired_task,
    output logic                           o_last_result
);
    import htw_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int HW = $clog2(MAX_TIMERS + 1);
    localparam int GW = $clog2(MAX_TIMERS + 1);
    localparam logic [HW-1:0] NONE = HW'(MAX_TIMERS);

    // Reciprocal of SLOTS, exact for any tick count and up to 256 slots
    localparam int RK = TW + 8;
    localparam longint RECIP_L = ((longint'(1) << RK) + longint'(SLOTS) - 1) / longint'(SLOTS);
    localparam logic [RK-1:0] RECIP = RK'(RECIP_L);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIV1  = 4'd1;
    localparam logic [3:0] ST_RND   = 4'd2;
    localparam logic [3:0] ST_ARD   = 4'd3;
    localparam logic [3:0] ST_AWR   = 4'd4;
    localparam logic [3:0] ST_THEAD = 4'd5;
    localparam logic [3:0] ST_THD2  = 4'd6;
    localparam logic [3:0] ST_TCHK  = 4'd7;
    localparam logic [3:0] ST_TEVAL = 4'd8;
    localparam logic [3:0] ST_TUNL  = 4'd9;
    localparam logic [3:0] ST_TEND  = 4'd10;
    localparam logic [3:0] ST_AENT  = 4'd11;

    // Entry and slot stores
    logic [RND_W-1:0] m_rounds [MAX_TIMERS];
    logic [RND_W-1:0] m_reload [MAX_TIMERS];
    logic [SW-1:0]    m_rem    [MAX_TIMERS];
    logic             m_per    [MAX_TIMERS];
    logic [ID_W-1:0]  m_task   [MAX_TIMERS];
    logic [HW-1:0]    m_link   [MAX_TIMERS];
    logic [HW-1:0]    m_head   [SLOTS];
    logic [EW-1:0]    m_tail   [SLOTS];

    logic [MAX_TIMERS-1:0] r_evalid;
    logic [SLOTS-1:0]      r_head_ok;

    logic [3:0]        r_state;
    logic [STEP_W-1:0] r_step;
    logic [SW-1:0]     r_last_slot, r_next_slot;
    logic [SW-1:0]     r_s, r_dest;
    logic [HW-1:0]     r_cur, r_prev, r_nxt;
    logic [EW-1:0]     r_tail_s;
    logic [GW-1:0]     r_guard;
    logic              r_add, r_loop;
    logic [ID_W-1:0]   r_task_in;
    logic              r_pend_ok;
    logic [ID_W-1:0]   r_pend_task;
    logic [TW-1:0]     r_rnd_q;

    logic              r_valid, r_last;
    t_kind             r_kind;
    logic [ID_W-1:0]   r_otask;

    // Registered read data
    logic [RND_W-1:0] q_rounds, q_reload;
    logic [SW-1:0]    q_rem;
    logic             q_per;
    logic [ID_W-1:0]  q_task;
    logic [HW-1:0]    q_link, q_head;
    logic [EW-1:0]    q_tail;
    logic             q_head_ok;

    logic accept;
    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Lowest free entry
    logic          t_full;
    logic [EW-1:0] t_free;
    always_comb begin
        t_full = 1'b1;
        t_free = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!r_evalid[i]) begin
                t_full = 1'b0;
                t_free = EW'(i);
            end
        end
    end

    // Divider, used by adds only: period by step
    logic          d_start, d_done;
    logic [TW-1:0] d_dvd, d_dvs, d_quot;
    htw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (d_start),
        .i_dividend (d_dvd),
        .i_divisor  (d_dvs),
        .o_done     (d_done),
        .o_quot     (d_quot)
    );
    assign d_start = accept && !i_req_type && !t_full;
    assign d_dvd   = i_timeout_ms;
    assign d_dvs   = (r_step == '0) ? TW'(1) : TW'(r_step);

    // Slot arithmetic
    logic [TW+RK-1:0] t_prod;
    logic [TW-1:0]    t_qs, t_trem;
    logic [SW-1:0]    t_rem_s;
    logic [SW:0]      t_sum_add, t_sum_tick;
    logic [SW-1:0]    t_slot_add, t_dest;
    logic [RND_W-1:0] t_sat;
    logic [SW-1:0]    t_next_s;
    localparam logic [SW:0] SLOTS_W = (SW + 1)'(SLOTS);
    always_comb begin
        t_prod     = (TW + RK)'(d_quot) * (TW + RK)'(RECIP);
        t_qs       = r_rnd_q * TW'(SLOTS);
        t_trem     = d_quot - t_qs;
        t_rem_s    = t_trem[SW-1:0];
        t_sum_add  = {1'b0, t_rem_s} + {1'b0, r_last_slot};
        t_slot_add = (t_sum_add >= SLOTS_W) ? SW'(t_sum_add - SLOTS_W) : t_sum_add[SW-1:0];
        t_sum_tick = {1'b0, q_rem} + {1'b0, r_s};
        t_dest     = (t_sum_tick >= SLOTS_W) ? SW'(t_sum_tick - SLOTS_W)
                                             : t_sum_tick[SW-1:0];
        t_sat      = (r_rnd_q > TW'(16'hFFFF)) ? 16'hFFFF : r_rnd_q[RND_W-1:0];
        t_next_s   = (r_next_slot == SW'(SLOTS - 1)) ? '0 : r_next_slot + 1'b1;
    end

    // Entry store writes and reads
    logic e_add_wr, e_rnd_wr;
    logic [RND_W-1:0] e_rnd_val;
    assign e_add_wr  = (r_state == ST_AENT);
    assign e_rnd_wr  = (r_state == ST_TEVAL);
    assign e_rnd_val = (q_rounds != '0) ? q_rounds - 1'b1 : q_reload;

    always_ff @(posedge i_clk) begin
        if (e_add_wr) begin
            m_rounds[r_cur[EW-1:0]] <= t_sat;
            m_reload[r_cur[EW-1:0]] <= t_sat;
            m_rem[r_cur[EW-1:0]]    <= t_rem_s;
            m_per[r_cur[EW-1:0]]    <= r_loop;
            m_task[r_cur[EW-1:0]]   <= r_task_in;
        end else if (e_rnd_wr && (q_rounds != '0 || q_per)) begin
            m_rounds[r_cur[EW-1:0]] <= e_rnd_val;
        end
        if (r_state == ST_TCHK) begin
            q_rounds <= m_rounds[r_cur[EW-1:0]];
            q_reload <= m_reload[r_cur[EW-1:0]];
            q_rem    <= m_rem[r_cur[EW-1:0]];
            q_per    <= m_per[r_cur[EW-1:0]];
            q_task   <= m_task[r_cur[EW-1:0]];
            q_link   <= m_link[r_cur[EW-1:0]];
        end
    end

    // Link store: at most one write per cycle
    always_ff @(posedge i_clk) begin
        priority case (1'b1)
            (r_state == ST_ARD):
                m_link[r_cur[EW-1:0]] <= NONE;
            (r_state == ST_AWR && q_head_ok && q_head != NONE):
                m_link[q_tail] <= r_cur;
            (r_state == ST_TUNL && r_prev != NONE):
                m_link[r_prev[EW-1:0]] <= r_nxt;
            default: ;
        endcase
    end

    // Slot stores
    logic [SW-1:0] t_saddr;
    assign t_saddr = (r_state == ST_THEAD) ? r_s : r_dest;
    always_ff @(posedge i_clk) begin
        if (r_state == ST_THEAD || r_state == ST_ARD) begin
            q_head <= m_head[t_saddr];
            q_tail <= m_tail[t_saddr];
        end
        if (r_state == ST_AWR) begin
            m_tail[r_dest] <= r_cur[EW-1:0];
            if (!q_head_ok || q_head == NONE)
                m_head[r_dest] <= r_cur;
        end else if (r_state == ST_TUNL) begin
            if (r_prev == NONE)
                m_head[r_s] <= r_nxt;
            if (r_tail_s == r_cur[EW-1:0] && r_prev != NONE)
                m_tail[r_s] <= r_prev[EW-1:0];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_RST;
            r_last_slot <= '0;
            r_next_slot <= '0;
            r_evalid    <= '0;
            r_head_ok   <= '0;
            r_valid     <= 1'b0;
            r_pend_ok   <= 1'b0;
            q_head_ok   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_step_ms_we)
                r_step <= i_step_ms;
            if (r_state == ST_THEAD || r_state == ST_ARD)
                q_head_ok <= r_head_ok[t_saddr];
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (!i_req_type) begin
                            r_add     <= 1'b1;
                            r_loop    <= i_timer_loop;
                            r_task_in <= i_task_id;
                            r_cur     <= HW'(t_free);
                            if (t_full) begin
                                r_valid <= 1'b1;
                                r_kind  <= KIND_ADD_FULL;
                                r_otask <= '0;
                                r_last  <= 1'b1;
                            end else begin
                                r_state <= ST_DIV1;
                            end
                        end else begin
                            r_add       <= 1'b0;
                            r_s         <= r_next_slot;
                            r_last_slot <= r_next_slot;
                            r_next_slot <= t_next_s;
                            r_pend_ok   <= 1'b0;
                            r_state     <= ST_THEAD;
                        end
                    end
                end
                ST_DIV1: begin
                    if (d_done)
                        r_state <= ST_RND;
                end
                // Split the ticks into rounds by the reciprocal of SLOTS
                ST_RND: begin
                    r_rnd_q <= t_prod[TW+RK-1:RK];
                    r_state <= ST_AENT;
                end
                ST_AENT: begin
                    r_evalid[r_cur[EW-1:0]] <= 1'b1;
                    r_dest  <= t_slot_add;
                    r_state <= ST_ARD;
                end
                ST_ARD: r_state <= ST_AWR;
                ST_AWR: begin
                    r_head_ok[r_dest] <= 1'b1;
                    if (r_add) begin
                        r_valid <= 1'b1;
                        r_kind  <= KIND_ADD_OK;
                        r_otask <= '0;
                        r_last  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cur   <= r_nxt;
                        r_state <= ST_TCHK;
                    end
                end
                ST_THEAD: r_state <= ST_THD2;
                ST_THD2: begin
                    r_cur    <= q_head_ok ? q_head : NONE;
                    r_tail_s <= q_tail;
                    r_prev   <= NONE;
                    r_guard  <= '0;
                    r_state  <= ST_TCHK;
                end
                ST_TCHK: begin
                    if (r_cur == NONE || r_guard == GW'(MAX_TIMERS))
                        r_state <= ST_TEND;
                    else
                        r_state <= ST_TEVAL;
                end
                ST_TEVAL: begin
                    r_guard <= r_guard + 1'b1;
                    r_nxt   <= q_link;
                    if (q_rounds != '0) begin
                        r_prev  <= r_cur;
                        r_cur   <= q_link;
                        r_state <= ST_TCHK;
                    end else begin
                        // hand out the previous firing, keep this one pending
                        if (r_pend_ok) begin
                            r_valid <= 1'b1;
                            r_kind  <= KIND_FIRED;
                            r_otask <= r_pend_task;
                            r_last  <= 1'b0;
                        end
                        r_pend_ok   <= 1'b1;
                        r_pend_task <= q_task;
                        r_dest      <= t_dest;
                        if (q_per && t_dest == r_s) begin
                            r_prev  <= r_cur;
                            r_cur   <= q_link;
                            r_state <= ST_TCHK;
                        end else begin
                            if (!q_per)
                                r_evalid[r_cur[EW-1:0]] <= 1'b0;
                            r_loop  <= q_per;
                            r_state <= ST_TUNL;
                        end
                    end
                end
                ST_TUNL: begin
                    if (r_tail_s == r_cur[EW-1:0] && r_prev != NONE)
                        r_tail_s <= r_prev[EW-1:0];
                    if (r_loop) begin
                        r_state <= ST_ARD;
                    end else begin
                        r_cur   <= r_nxt;
                        r_state <= ST_TCHK;
                    end
                end
                ST_TEND: begin
                    r_valid   <= 1'b1;
                    r_last    <= 1'b1;
                    r_kind    <= r_pend_ok ? KIND_FIRED : KIND_IDLE;
                    r_otask   <= r_pend_ok ? r_pend_task : '0;
                    r_pend_ok <= 1'b0;
                    r_state   <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_out_kind    = r_kind;
    assign o_fired_task  = r_otask;
    assign o_last_result = r_last;

    // Checks
    a_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind != KIND_FIRED |-> o_fired_task == '0)
        else $error("nonzero task on a result without a firing");
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req_type |=> busy)
        else $error("tick transaction did not raise busy");
    a_div_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        d_done |-> r_state == ST_DIV1)
        else $error("divider finished outside an add");
endmodule
`default_nettype wire
